### hdl/argb_pixel_alpha_blend_top_defines.svh
// ----------------------------------------------------------------------------
// ARGB pixel alpha blend assertion macros
// Concurrent assertion shorthands sampled on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ARGB_PIXEL_ALPHA_BLEND_TOP_DEFINES_SVH
`define ARGB_PIXEL_ALPHA_BLEND_TOP_DEFINES_SVH

// check consequent in the same cycle as the antecedent
`define APB_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// check consequent in the cycle after the antecedent
`define APB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/apb_pkg.sv
// ----------------------------------------------------------------------------
// ARGB pixel alpha blend package
// Widths, command and register codes, divider stage type, divide-by-255.
// ----------------------------------------------------------------------------
package apb_pkg;

   localparam int CHAN_N      = 3;
   localparam int CHAN_W      = 8;
   localparam int PIX_W       = 32;
   localparam int RGB_W       = CHAN_N * CHAN_W;
   localparam int CMD_W       = 3;
   localparam int PROD_W      = 2 * CHAN_W;
   localparam int SUM_W       = PROD_W + 1;
   localparam int D_W         = 16;
   localparam int REM_W       = 25;
   localparam int RECIP_W     = 32;
   localparam int RECIP_SHIFT = 23;
   localparam logic [RECIP_W-1:0] RECIP_255 = 32'd32897;
   localparam int BITS_PER_DIV = 2;
   localparam int DIV_N       = CHAN_W / BITS_PER_DIV;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CHAN_W-1:0] OPACITY_RESET = 8'hFF;
   localparam logic [RGB_W-1:0]  TEXT_COLOR_RESET = 24'h000000;

   typedef enum logic [CMD_W-1:0] {
      CMD_BLEND   = 3'd0,
      CMD_SCALE   = 3'd1,
      CMD_REPLACE = 3'd2,
      CMD_COPY    = 3'd3,
      CMD_TEXT    = 3'd4
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OPACITY    = 2'd0,
      CSR_TEXT_COLOR = 2'd1
   } csr_index_type;

   typedef logic [CHAN_N-1:0][CHAN_W-1:0] rgb_type;

   typedef struct packed {
      logic [D_W-1:0]                d;
      logic [CHAN_N-1:0][REM_W-1:0]  rem;
      logic [CHAN_N-1:0][CHAN_W-1:0] quo;
   } div_type;

   typedef struct packed {
      logic              byp;
      logic [PIX_W-1:0]  val;
      logic [CHAN_W-1:0] alpha;
   } side_type;

   function automatic logic [CHAN_W-1:0] div255(input logic [D_W-1:0] x);
      logic [RECIP_W-1:0] prod;
      prod = RECIP_W'(x) * RECIP_255;
      return prod[RECIP_SHIFT +: CHAN_W];
   endfunction

endpackage

### hdl/apb_div_stage.sv
// ----------------------------------------------------------------------------
// ARGB pixel alpha blend divider stage
// Two restoring quotient bits per channel, registered, with stall hold.
// ----------------------------------------------------------------------------
module apb_div_stage
   import apb_pkg::*;
#(
   parameter int TOP_BIT = CHAN_W - 1
) (
   input  logic    clock,
   input  logic    advance,
   input  div_type div_in,
   output div_type div_out
);

   localparam int HI = TOP_BIT;
   localparam int LO = TOP_BIT - 1;

   div_type          div_ff;
   div_type          div_in_nxt;
   logic [REM_W-1:0] dsh_hi;
   logic [REM_W-1:0] dsh_lo;

   assign dsh_hi = REM_W'(div_in.d) << HI;
   assign dsh_lo = REM_W'(div_in.d) << LO;

   always_comb begin
      div_in_nxt = div_in;
      for (int c = 0; c < CHAN_N; c++) begin
         if (div_in_nxt.rem[c] >= dsh_hi) begin
            div_in_nxt.rem[c]     = div_in_nxt.rem[c] - dsh_hi;
            div_in_nxt.quo[c][HI] = 1'b1;
         end
         if (div_in_nxt.rem[c] >= dsh_lo) begin
            div_in_nxt.rem[c]     = div_in_nxt.rem[c] - dsh_lo;
            div_in_nxt.quo[c][LO] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_ff <= div_in_nxt;
      end
   end

   assign div_out = div_ff;

endmodule

### hdl/argb_pixel_alpha_blend_top.sv
// Ten register stages, no loop back to the input; an rsp stall holds the pipe.
// Throughput: one beat per cycle while rsp_stall does not hold the pipe.
// The per-channel divide by the blend denominator runs as four stages of
// two restoring quotient bits each; the other stages hold the multiplies and subtracts.
// Reset: synchronous; empties all stages, opacity to 255, text color to 0.
// ----------------------------------------------------------------------------
// ARGB pixel alpha blend top level
// Source-over compositing of ARGB8888 pixels in a stallable pipeline.
// ----------------------------------------------------------------------------
`include "argb_pixel_alpha_blend_top_defines.svh"

module argb_pixel_alpha_blend_top
   import apb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [PIX_W-1:0]      req_src_pixel,
   input  logic [PIX_W-1:0]      req_dst_pixel,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIX_W-1:0]      rsp_out_pixel,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int STAGE_N = 10;
   localparam int LAST    = STAGE_N - 1;
   localparam int ST_NUM  = 4;
   localparam int ST_DIV0 = ST_NUM + 1;
   localparam int ST_DIVL = ST_DIV0 + DIV_N - 1;

   logic [STAGE_N-1:0] v_ff;
   logic [STAGE_N-1:0] en;

   logic [CHAN_W-1:0] opacity_ff;
   logic [RGB_W-1:0]  text_color_ff;

   // stage 0
   logic [CHAN_W-1:0] fa_raw_in, fa_raw0_ff;
   logic              scale_in, scale0_ff;
   logic [RGB_W-1:0]  fc_in;
   logic              byp_in;
   logic [PIX_W-1:0]  bv_in;
   logic [PROD_W-1:0] pa0_ff;
   rgb_type           fc0_ff, bc0_ff;
   logic [CHAN_W-1:0] ba0_ff;
   logic              byp0_ff;
   logic [PIX_W-1:0]  bv0_ff;

   // stage 1
   logic [CHAN_W-1:0] fa1_ff, ba1_ff;
   rgb_type           fc1_ff, bc1_ff;
   logic              byp1_ff;
   logic [PIX_W-1:0]  bv1_ff;

   // stage 2
   logic [CHAN_W-1:0]             fa2_ff, ba2_ff;
   logic [PROD_W-1:0]             faba2_ff;
   logic [CHAN_N-1:0][PROD_W-1:0] pf2_ff, pb2_ff;
   rgb_type                       bc2_ff;
   logic                          byp2_ff;
   logic [PIX_W-1:0]              bv2_ff;

   // stage 3
   logic [SUM_W-1:0]             asum_in, a255_in;
   logic [CHAN_N-1:0][REM_W-1:0] psum_in;
   logic [D_W-1:0]               d3_ff;
   logic [CHAN_N-1:0][REM_W-1:0] s3_ff, t3_ff;
   logic                         byp3_ff;
   logic [PIX_W-1:0]             bv3_ff;

   // stage 4 and divider
   div_type  num_ff;
   div_type  div_s [DIV_N+1];
   side_type side_in;
   side_type side_ff [ST_NUM:ST_DIVL];
   logic [PIX_W-1:0] rsp_out_pixel_ff;

   // ---------------------------------------------------------------- csr
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         opacity_ff    <= OPACITY_RESET;
         text_color_ff <= TEXT_COLOR_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_OPACITY:    opacity_ff    <= csr_data[CHAN_W-1:0];
            CSR_TEXT_COLOR: text_color_ff <= csr_data[RGB_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- flow control
   always_comb begin
      en[LAST] = !v_ff[LAST] || !rsp_stall;
      for (int i = LAST - 1; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign req_stall = !en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int i = 1; i < STAGE_N; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // --------------------------------------------------- stage 0: decode
   always_comb begin
      fa_raw_in = req_src_pixel[PIX_W-1 -: CHAN_W];
      scale_in  = 1'b0;
      fc_in     = req_src_pixel[RGB_W-1:0];
      byp_in    = 1'b0;
      bv_in     = req_dst_pixel;
      unique case (cmd_type'(req_command))
         CMD_BLEND: ;
         CMD_SCALE: scale_in = 1'b1;
         CMD_REPLACE: fa_raw_in = opacity_ff;
         CMD_COPY: begin
            byp_in = 1'b1;
            bv_in  = req_src_pixel;
         end
         CMD_TEXT: begin
            fa_raw_in = req_src_pixel[CHAN_W-1:0];
            fc_in     = text_color_ff;
         end
         default: byp_in = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         fa_raw0_ff <= fa_raw_in;
         scale0_ff  <= scale_in;
         pa0_ff     <= PROD_W'(req_src_pixel[PIX_W-1 -: CHAN_W]) * PROD_W'(opacity_ff);
         fc0_ff     <= fc_in;
         bc0_ff     <= req_dst_pixel[RGB_W-1:0];
         ba0_ff     <= req_dst_pixel[PIX_W-1 -: CHAN_W];
         byp0_ff    <= byp_in;
         bv0_ff     <= bv_in;
      end
   end

   // ------------------------------------------- stage 1: effective alpha
   always_ff @(posedge clock) begin
      if (en[1]) begin
         fa1_ff  <= scale0_ff ? div255(D_W'(pa0_ff)) : fa_raw0_ff;
         ba1_ff  <= ba0_ff;
         fc1_ff  <= fc0_ff;
         bc1_ff  <= bc0_ff;
         byp1_ff <= byp0_ff;
         bv1_ff  <= bv0_ff;
      end
   end

   // ------------------------------------------------ stage 2: products
   always_ff @(posedge clock) begin
      if (en[2]) begin
         faba2_ff <= PROD_W'(fa1_ff) * PROD_W'(ba1_ff);
         for (int c = 0; c < CHAN_N; c++) begin
            pf2_ff[c] <= PROD_W'(fc1_ff[c]) * PROD_W'(fa1_ff);
            pb2_ff[c] <= PROD_W'(bc1_ff[c]) * PROD_W'(ba1_ff);
         end
         fa2_ff  <= fa1_ff;
         ba2_ff  <= ba1_ff;
         bc2_ff  <= bc1_ff;
         byp2_ff <= byp1_ff;
         bv2_ff  <= bv1_ff;
      end
   end

   // ------------------------------------ stage 3: denominator and terms
   assign asum_in = SUM_W'(fa2_ff) + SUM_W'(ba2_ff);
   assign a255_in = (asum_in << CHAN_W) - asum_in;

   always_comb begin
      for (int c = 0; c < CHAN_N; c++) begin
         psum_in[c] = REM_W'(pf2_ff[c]) + REM_W'(pb2_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         d3_ff <= D_W'(a255_in - SUM_W'(faba2_ff));
         for (int c = 0; c < CHAN_N; c++) begin
            s3_ff[c] <= (psum_in[c] << CHAN_W) - psum_in[c];
            t3_ff[c] <= REM_W'(bc2_ff[c]) * REM_W'(faba2_ff);
         end
         byp3_ff <= byp2_ff;
         bv3_ff  <= bv2_ff;
      end
   end

   // ------------------------------------ stage 4: numerators and alpha
   always_comb begin
      side_in.byp   = byp3_ff || (d3_ff == '0);
      side_in.val   = byp3_ff ? bv3_ff : '0;
      side_in.alpha = div255(d3_ff);
   end

   always_ff @(posedge clock) begin
      if (en[ST_NUM]) begin
         num_ff.d   <= d3_ff;
         num_ff.quo <= '0;
         for (int c = 0; c < CHAN_N; c++) begin
            num_ff.rem[c] <= s3_ff[c] - t3_ff[c];
         end
      end
   end

   // ----------------------------------------------------------- divider
   assign div_s[0] = num_ff;

   for (genvar k = 0; k < DIV_N; k++) begin : g_div
      apb_div_stage #(
         .TOP_BIT(CHAN_W - 1 - BITS_PER_DIV * k)
      ) u_div (
         .clock   (clock),
         .advance (en[ST_DIV0+k]),
         .div_in  (div_s[k]),
         .div_out (div_s[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (en[ST_NUM]) begin
         side_ff[ST_NUM] <= side_in;
      end
      for (int i = ST_DIV0; i <= ST_DIVL; i++) begin
         if (en[i]) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // ------------------------------------------------------ output stage
   always_ff @(posedge clock) begin
      if (en[LAST]) begin
         rsp_out_pixel_ff <= side_ff[ST_DIVL].byp ? side_ff[ST_DIVL].val :
                             {side_ff[ST_DIVL].alpha, div_s[DIV_N].quo};
      end
   end

   assign rsp_valid     = v_ff[LAST];
   assign rsp_out_pixel = rsp_out_pixel_ff;

   // -------------------------------------------------------- assertions
   `APB_ASSERT_SAME(a_stall_source, req_stall, rsp_stall && (&v_ff), "input stalled without a full blocked pipe")
   `APB_ASSERT_NEXT(a_num_hold, v_ff[ST_NUM] && !en[ST_NUM], v_ff[ST_NUM] && $stable(num_ff), "divider entry beat lost while held")
   `APB_ASSERT_SAME(a_zero_bypass, v_ff[ST_NUM] && (num_ff.d == '0), side_ff[ST_NUM].byp, "zero denominator not bypassed")
   `APB_ASSERT_SAME(a_rem_range, v_ff[ST_DIVL] && !side_ff[ST_DIVL].byp, (div_s[DIV_N].rem[0] < REM_W'(div_s[DIV_N].d)) && (div_s[DIV_N].rem[1] < REM_W'(div_s[DIV_N].d)) && (div_s[DIV_N].rem[2] < REM_W'(div_s[DIV_N].d)), "divider remainder out of range")
   `APB_ASSERT_NEXT(a_opacity_write, csr_valid && csr_ready && (csr_index == CSR_OPACITY), opacity_ff == $past(csr_data[CHAN_W-1:0]), "opacity write not taken")

endmodule

### tb/sv/tb_argb_pixel_alpha_blend_top.sv
// ----------------------------------------------------------------------------
// ARGB pixel alpha blend testbench
// Streams source/destination pixel pairs through the blend pipeline under
// random valid gaps and result stalls, and checks every composited pixel
// against an in-bench integer source-over model. Opacity and text color are
// reprogrammed between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_argb_pixel_alpha_blend_top;
   import apb_pkg::*;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [PIX_W-1:0] src;
      logic [PIX_W-1:0] dst;
   } pixel_job_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CMD_W-1:0]      req_command = CMD_BLEND;
   logic [PIX_W-1:0]      req_src_pixel = '0;
   logic [PIX_W-1:0]      req_dst_pixel = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PIX_W-1:0]      rsp_out_pixel;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_OPACITY;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   pixel_job_type     pixel_jobs[$];
   logic [PIX_W-1:0]  expected_out_pixels[$];
   logic [CHAN_W-1:0] opacity_cfg = OPACITY_RESET;
   logic [RGB_W-1:0]  text_color_cfg = TEXT_COLOR_RESET;
   logic [PIX_W-1:0]  want_pixel;
   logic              req_took = 1'b0;
   logic              rsp_hold = 1'b0;
   int                jobs_queued = 0;
   int                jobs_accepted = 0;
   int                mismatch_count = 0;
   int                req_gap = 0;
   int                req_calm = 0;
   int                rsp_wait = 0;
   int                rsp_calm = 0;

   argb_pixel_alpha_blend_top u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_src_pixel (req_src_pixel),
      .req_dst_pixel (req_dst_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_pixel (rsp_out_pixel),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [PIX_W-1:0] source_over(input logic [PIX_W-1:0] fg,
                                                    input logic [PIX_W-1:0] bg);
      logic [39:0]      fa, ba, fc, bc, den, num, quo;
      logic [PIX_W-1:0] res;
      int               c;
      fa  = 40'(fg[31:24]);
      ba  = 40'(bg[31:24]);
      den = 40'd255 * (fa + ba) - fa * ba;
      if (den == 40'd0) return '0;
      quo = den / 40'd255;
      res = {quo[7:0], 24'h0};
      for (c = 0; c < CHAN_N; c++) begin
         fc  = 40'(fg[CHAN_W*c +: CHAN_W]);
         bc  = 40'(bg[CHAN_W*c +: CHAN_W]);
         num = 40'd255 * (fc * fa + bc * ba) - bc * fa * ba;
         quo = num / den;
         if (quo > 40'd255) quo = 40'd255;
         res[CHAN_W*c +: CHAN_W] = quo[7:0];
      end
      return res;
   endfunction

   function automatic logic [PIX_W-1:0] composite_pixel(input logic [CMD_W-1:0] cmd,
                                                        input logic [PIX_W-1:0] src,
                                                        input logic [PIX_W-1:0] dst);
      logic [15:0] scaled;
      case (cmd)
         CMD_BLEND: return source_over(src, dst);
         CMD_SCALE: begin
            scaled = (16'(src[31:24]) * 16'(opacity_cfg)) / 16'd255;
            return source_over({scaled[7:0], src[23:0]}, dst);
         end
         CMD_REPLACE: return source_over({opacity_cfg, src[23:0]}, dst);
         CMD_COPY:    return src;
         CMD_TEXT:    return source_over({src[7:0], text_color_cfg}, dst);
         default:     return dst;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [PIX_W-1:0] random_pixel();
      logic [7:0]  a;
      logic [23:0] rgb;
      case ($urandom_range(0, 9))
         0:       a = 8'h00;
         1:       a = 8'hFF;
         2:       a = 8'($urandom_range(1, 3));
         3:       a = 8'($urandom_range(252, 254));
         default: a = 8'($urandom);
      endcase
      case ($urandom_range(0, 19))
         0:       rgb = 24'h000000;
         1:       rgb = 24'hFFFFFF;
         default: rgb = 24'($urandom);
      endcase
      return {a, rgb};
   endfunction

   function automatic void queue_job(input logic [CMD_W-1:0] cmd,
                                     input logic [PIX_W-1:0] src,
                                     input logic [PIX_W-1:0] dst);
      pixel_job_type job;
      job.command = cmd;
      job.src     = src;
      job.dst     = dst;
      pixel_jobs.push_back(job);
      jobs_queued++;
   endfunction

   task automatic wait_drained();
      while (jobs_accepted != jobs_queued || expected_out_pixels.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_OPACITY)
         opacity_cfg = data[CHAN_W-1:0];
      else if (idx == CSR_TEXT_COLOR)
         text_color_cfg = data[RGB_W-1:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_took) begin
            void'(pixel_jobs.pop_front());
            if (req_calm > 0) begin
               req_calm--;
               req_gap = 0;
            end else begin
               req_gap = pick_gap();
               if ($urandom_range(0, 19) == 0) req_calm = $urandom_range(20, 80);
            end
         end
         if (!req_valid || req_took) begin
            if (req_gap > 0 || pixel_jobs.size() == 0) begin
               req_valid <= 1'b0;
               if (req_gap > 0) req_gap--;
            end else begin
               req_valid     <= 1'b1;
               req_command   <= pixel_jobs[0].command;
               req_src_pixel <= pixel_jobs[0].src;
               req_dst_pixel <= pixel_jobs[0].dst;
            end
         end
      end
   end

   // result stall driver
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_hold) begin
         rsp_stall <= 1'b1;
      end else if (rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait--;
      end else begin
         rsp_stall <= 1'b0;
         if (rsp_calm > 0) begin
            rsp_calm--;
         end else begin
            rsp_wait = pick_gap();
            if ($urandom_range(0, 19) == 0) rsp_calm = $urandom_range(20, 80);
         end
      end
   end

   // predict on accepted req beats, check accepted rsp beats
   always @(posedge clock) begin
      if (reset) begin
         req_took = 1'b0;
      end else begin
         req_took = req_valid && !req_stall;
         if (req_took) begin
            expected_out_pixels.push_back(
               composite_pixel(req_command, req_src_pixel, req_dst_pixel));
            jobs_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_out_pixels.size() == 0) begin
               $display("%0t: unexpected out_pixel beat, actual %h", $time, rsp_out_pixel);
               mismatch_count++;
            end else begin
               want_pixel = expected_out_pixels.pop_front();
               if (rsp_out_pixel !== want_pixel) begin
                  $display("%0t: out_pixel expected %h actual %h",
                           $time, want_pixel, rsp_out_pixel);
                  mismatch_count++;
               end
            end
         end
      end
   end

   initial begin
      int               p;
      int               k;
      int               r;
      logic [7:0]       op;
      logic [23:0]      tc;
      logic [CMD_W-1:0] cmd;
      logic [31:0]      word;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_job(CMD_BLEND,   32'h00FFFFFF, 32'h00123456);
      queue_job(CMD_BLEND,   32'hFF112233, 32'h80445566);
      queue_job(CMD_BLEND,   32'h00112233, 32'hFF445566);
      queue_job(CMD_BLEND,   32'h80FFFFFF, 32'h80000000);
      queue_job(CMD_BLEND,   32'hFFFFFFFF, 32'hFFFFFFFF);
      queue_job(CMD_BLEND,   32'h01000000, 32'h00FFFFFF);
      queue_job(CMD_BLEND,   32'h7F804020, 32'h3FC0E0F0);
      queue_job(CMD_SCALE,   32'hFF102030, 32'h00000000);
      queue_job(CMD_SCALE,   32'h80A0B0C0, 32'hFF0F0F0F);
      queue_job(CMD_REPLACE, 32'h00ABCDEF, 32'h40123456);
      queue_job(CMD_COPY,    32'hFFFFFFFF, 32'h00000000);
      queue_job(CMD_COPY,    32'h00000000, 32'hFFFFFFFF);
      queue_job(CMD_TEXT,    32'h000000FF, 32'h00FFFFFF);
      queue_job(CMD_TEXT,    32'hFFFFFF00, 32'h00000000);
      queue_job(3'd5,        32'h12345678, 32'h9ABCDEF0);
      queue_job(3'd6,        32'hFFFFFFFF, 32'h00000000);
      queue_job(3'd7,        32'h00000000, 32'hFFFFFFFF);
      wait_drained();

      write_csr(CSR_OPACITY, 32'h00000000);
      write_csr(CSR_TEXT_COLOR, 32'h00FFFFFF);
      queue_job(CMD_SCALE,   32'hFFFFFFFF, 32'h00000000);
      queue_job(CMD_SCALE,   32'hFF123456, 32'h80654321);
      queue_job(CMD_REPLACE, 32'hFF123456, 32'h00000000);
      queue_job(CMD_REPLACE, 32'h00ABCDEF, 32'hFF000000);
      queue_job(CMD_TEXT,    32'h00000080, 32'h80000000);
      queue_job(CMD_TEXT,    32'h000000FF, 32'hFF000000);
      wait_drained();

      for (p = 0; p < 8; p++) begin
         case (p)
            0:       begin op = 8'd255; tc = 24'h000000; end
            1:       begin op = 8'd0;   tc = 24'hFFFFFF; end
            2:       begin op = 8'd1;   tc = 24'h800000; end
            3:       begin op = 8'd254; tc = 24'h00FF00; end
            4:       begin op = 8'd128; tc = 24'h0000FF; end
            default: begin op = 8'($urandom); tc = 24'($urandom); end
         endcase
         word = $urandom;
         word[7:0] = op;
         write_csr(CSR_OPACITY, word);
         word = $urandom;
         word[23:0] = tc;
         write_csr(CSR_TEXT_COLOR, word);
         for (k = 0; k < 125; k++) begin
            r = $urandom_range(0, 99);
            if (r < 94) cmd = 3'(r % 5);
            else cmd = 3'($urandom_range(5, 7));
            queue_job(cmd, random_pixel(), random_pixel());
         end
         if (p == 3) begin
            @(posedge clock);
            rsp_hold = 1'b1;
            repeat (300) @(posedge clock);
            rsp_hold = 1'b0;
         end
         wait_drained();
      end

      repeat (30) @(negedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
